FILE: hdl/drim_pkg.sv
// ----------------------------------------------------------------------------
// drim_pkg
// Shared types and constants of the dirty range interval merger.
// ----------------------------------------------------------------------------
package drim_pkg;

  localparam int unsigned MaxIntervalsDefault = 16;
  localparam int unsigned AddrW = 32;

  typedef enum logic [0:0] {
    CMD_MARK  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE,
    ST_SHL_RD,
    ST_SHL_WR,
    ST_SHR_RD,
    ST_SHR_WR,
    ST_INSERT,
    ST_FL_RD,
    ST_FL_OUT,
    ST_FL_EMPTY
  } state_e;

  // one table entry
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] len;
  } entry_t;

  // table memory access request from the controller
  typedef struct packed {
    logic   we;
    logic   re;
    entry_t wdata;
  } mem_ctl_t;

endpackage

FILE: hdl/drim_table.sv
// ----------------------------------------------------------------------------
// drim_table
// Interval table: one synchronous memory, one write and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module drim_table #(
  parameter int unsigned Depth = drim_pkg::MaxIntervalsDefault,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic              clk_i,
  input  drim_pkg::mem_ctl_t ctl_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  logic [IdxW-1:0]   raddr_i,
  output drim_pkg::entry_t  rdata_o
);

  drim_pkg::entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= ctl_i.wdata;
    end
    if (ctl_i.re) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/dirty_range_interval_merger.sv
// ----------------------------------------------------------------------------
// dirty_range_interval_merger
// Records changed byte ranges of a buffer as sorted disjoint intervals.
// ----------------------------------------------------------------------------
// A mark word clamps its range to block_size and merges it into a table of at
// most MAX_INTERVALS sorted intervals kept in one single-port-read memory; a
// flush word emits every interval in order (last flagged) and empties the
// table, or emits (0, block_size) when it is empty. One word is processed at a
// time. A mark reads the entries one by one up to the end of the merged run,
// then shifts entries, each read and then written back, when a merge closes
// a gap or an insert opens one; the memory's read data is registered. A flush
// reads and emits the intervals one at a time, holding while the output is
// stalled. A table that would need one more entry than it holds collapses
// to the whole block and sets overflowed until the next flush. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module dirty_range_interval_merger #(
  parameter int unsigned MAX_INTERVALS = drim_pkg::MaxIntervalsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] range_from_i,
  input  logic [31:0] range_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] interval_start_o,
  output logic [31:0] interval_length_o,
  output logic        last_o,
  output logic        overflowed_o
);

  localparam int unsigned IdxW = $clog2(MAX_INTERVALS);
  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_INTERVALS);

  drim_pkg::state_e state_q, state_d;
  logic [31:0] block_size_q;
  logic [CntW-1:0] count_q, count_d;
  logic ovf_q, ovf_d;
  logic [32:0] a_q, a_d, b_q, b_d;          // merged range, 33-bit end
  logic [CntW-1:0] lo_q, lo_d, idx_q, idx_d; // run start, walk pointer
  logic found_q, found_d;                    // lo has been fixed
  logic [CntW-1:0] rem_q, rem_d;             // entries dropped by merge

  drim_pkg::mem_ctl_t mctl;
  logic [CntW-1:0] waddr, raddr;
  drim_pkg::entry_t rdata;

  logic out_valid_q, out_valid_d;
  logic [31:0] ostart_q, ostart_d, olen_q, olen_d;
  logic olast_q, olast_d, oovf_q, oovf_d;

  drim_table #(.Depth(MAX_INTERVALS), .IdxW(IdxW)) u_table (
    .clk_i  (clk_i),
    .ctl_i  (mctl),
    .waddr_i(waddr[IdxW-1:0]),
    .raddr_i(raddr[IdxW-1:0]),
    .rdata_o(rdata)
  );

  logic [32:0] rd_end;
  logic [31:0] clamp_len;
  logic [31:0] avail;
  assign rd_end = {1'b0, rdata.start} + {1'b0, rdata.len};
  assign avail  = block_size_q - range_from_i;
  assign clamp_len = (range_length_i == '0 || range_length_i > avail) ? avail : range_length_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= drim_pkg::ST_IDLE;
      block_size_q <= '0;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        block_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; lo_q <= lo_d; idx_q <= idx_d;
    found_q <= found_d; rem_q <= rem_d;
    ostart_q <= ostart_d; olen_q <= olen_d; olast_q <= olast_d; oovf_q <= oovf_d;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q; ovf_d = ovf_q;
    a_d = a_q; b_d = b_q; lo_d = lo_q; idx_d = idx_q;
    found_d = found_q; rem_d = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    ostart_d = ostart_q; olen_d = olen_q; olast_d = olast_q; oovf_d = oovf_q;
    mctl = '0;
    waddr = idx_q;
    raddr = idx_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      drim_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (command_i == drim_pkg::CMD_FLUSH) begin
            idx_d = '0;
            state_d = (count_q == '0) ? drim_pkg::ST_FL_EMPTY : drim_pkg::ST_FL_RD;
          end else if (range_from_i < block_size_q) begin
            a_d = {1'b0, range_from_i};
            b_d = {1'b0, range_from_i} + {1'b0, clamp_len};
            idx_d = '0; found_d = 1'b0;
            state_d = drim_pkg::ST_SCAN_RD;
          end
        end
      end
      // issue read of entry idx, or finish the walk
      drim_pkg::ST_SCAN_RD: begin
        if (idx_q == count_q) begin
          if (!found_q) lo_d = idx_q;
          state_d = drim_pkg::ST_DECIDE;
        end else begin
          mctl.re = 1'b1;
          state_d = drim_pkg::ST_SCAN;
        end
      end
      drim_pkg::ST_SCAN: begin
        state_d = drim_pkg::ST_SCAN_RD;
        if (!found_q && rd_end < a_q) begin
          idx_d = idx_q + 1'b1;
        end else if ({1'b0, rdata.start} <= b_q) begin
          if (!found_q) begin
            lo_d = idx_q; found_d = 1'b1;
          end
          if ({1'b0, rdata.start} < a_q) a_d = {1'b0, rdata.start};
          if (rd_end > b_q) b_d = rd_end;
          idx_d = idx_q + 1'b1;
        end else begin
          if (!found_q) lo_d = idx_q;
          found_d = 1'b1;
          state_d = drim_pkg::ST_DECIDE;
        end
      end
      // idx now holds hi; merged run when found with hi > lo
      drim_pkg::ST_DECIDE: begin
        if (found_q && idx_q > lo_q) begin
          rem_d = idx_q - lo_q - 1'b1;
          state_d = drim_pkg::ST_WRITE;
        end else if (count_q >= CntMax) begin
          mctl.we = 1'b1;
          waddr = '0;
          mctl.wdata.start = '0;
          mctl.wdata.len = block_size_q;
          count_d = CntW'(1);
          ovf_d = 1'b1;
          state_d = drim_pkg::ST_IDLE;
        end else begin
          idx_d = count_q;
          state_d = drim_pkg::ST_SHR_RD;
        end
      end
      drim_pkg::ST_WRITE: begin
        mctl.we = 1'b1;
        waddr = lo_q;
        mctl.wdata.start = a_q[31:0];
        mctl.wdata.len = 32'(b_q - a_q);
        idx_d = lo_q + 1'b1;
        state_d = (rem_q == '0) ? drim_pkg::ST_IDLE : drim_pkg::ST_SHL_RD;
      end
      // close the gap: k from lo+1 while k+rem < count
      drim_pkg::ST_SHL_RD: begin
        if (idx_q + rem_q >= count_q) begin
          count_d = count_q - rem_q;
          state_d = drim_pkg::ST_IDLE;
        end else begin
          mctl.re = 1'b1;
          raddr = idx_q + rem_q;
          state_d = drim_pkg::ST_SHL_WR;
        end
      end
      drim_pkg::ST_SHL_WR: begin
        mctl.we = 1'b1;
        mctl.wdata = rdata;
        idx_d = idx_q + 1'b1;
        state_d = drim_pkg::ST_SHL_RD;
      end
      // open a gap: k from count down to lo+1
      drim_pkg::ST_SHR_RD: begin
        if (idx_q == lo_q) begin
          state_d = drim_pkg::ST_INSERT;
        end else begin
          mctl.re = 1'b1;
          raddr = idx_q - 1'b1;
          state_d = drim_pkg::ST_SHR_WR;
        end
      end
      drim_pkg::ST_SHR_WR: begin
        mctl.we = 1'b1;
        mctl.wdata = rdata;
        idx_d = idx_q - 1'b1;
        state_d = drim_pkg::ST_SHR_RD;
      end
      drim_pkg::ST_INSERT: begin
        mctl.we = 1'b1;
        waddr = lo_q;
        mctl.wdata.start = a_q[31:0];
        mctl.wdata.len = 32'(b_q - a_q);
        count_d = count_q + 1'b1;
        state_d = drim_pkg::ST_IDLE;
      end
      // flush: read entry, then hand it to the output register
      drim_pkg::ST_FL_RD: begin
        mctl.re = 1'b1;
        state_d = drim_pkg::ST_FL_OUT;
      end
      drim_pkg::ST_FL_OUT: begin
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          ostart_d = rdata.start;
          olen_d = rdata.len;
          olast_d = (idx_q + 1'b1 == count_q);
          oovf_d = ovf_q;
          idx_d = idx_q + 1'b1;
          if (idx_q + 1'b1 == count_q) begin
            count_d = '0; ovf_d = 1'b0;
            state_d = drim_pkg::ST_IDLE;
          end else begin
            state_d = drim_pkg::ST_FL_RD;
          end
        end
      end
      drim_pkg::ST_FL_EMPTY: begin
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          ostart_d = '0;
          olen_d = block_size_q;
          olast_d = 1'b1;
          oovf_d = ovf_q;
          ovf_d = 1'b0;
          state_d = drim_pkg::ST_IDLE;
        end
      end
      default: state_d = drim_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign interval_start_o = ostart_q;
  assign interval_length_o = olen_q;
  assign last_o = olast_q;
  assign overflowed_o = oovf_q;

  // table never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("entry count exceeds table depth");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(interval_start_o)
      && $stable(last_o)) else $error("stalled result changed");

  // a flush always leaves an empty table with the flag cleared
  a_flush_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_d && !out_valid_q && olast_d |=> count_q == '0 && !ovf_q)
    else $error("flush did not clear table");

endmodule
